// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition implies another one in the same cycle.
`define BBPT_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("bbpt: same-cycle check failed");

// A condition implies another one in the next cycle.
`define BBPT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("bbpt: next-cycle check failed");

`endif

// File: hw/rtl/bbpt_pkg.sv
// Package with the shared types and constants of the Bollinger band tracker.
`default_nettype none
package bbpt_pkg;
	localparam int WINDOW_DEF     = 20;
	localparam int PRICE_BITS_DEF = 24;
	localparam int PRICE_W        = 24;
	localparam int THR_W          = 41;
	localparam int CNT_W          = 32;
	localparam int TOT_W          = 64;
	localparam int ACT_W          = 3;
	localparam int FRAC_BITS      = 16;
	localparam int QDEPTH         = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE      = 3'd0,
		ACT_LONG_IN   = 3'd1,
		ACT_LONG_OUT  = 3'd2,
		ACT_SHORT_IN  = 3'd3,
		ACT_SHORT_OUT = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		POS_FLAT  = 2'd0,
		POS_LONG  = 2'd1,
		POS_SHORT = 2'd2
	} pos_t;

	// One classified candle handed from the front to the back.
	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               final_c;
		logic               decide;
		logic               at_lower;
		logic               at_upper;
		logic               d_pos;
		logic               d_neg;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;
endpackage
`default_nettype wire

// File: hw/rtl/bbpt_if.sv
// Valid/ready channel interfaces for candle input and result output.
`default_nettype none
interface bbpt_in_if;
	logic                          valid;
	logic                          ready;
	logic [bbpt_pkg::PRICE_W-1:0]  close_price;
	logic                          final_candle;
	modport source (output valid, output close_price, output final_candle, input ready);
	modport sink (input valid, input close_price, input final_candle, output ready);
endinterface

interface bbpt_out_if;
	logic                          valid;
	logic                          ready;
	logic [bbpt_pkg::ACT_W-1:0]    action_code;
	logic [bbpt_pkg::THR_W-1:0]    trade_return;
	logic                          trade_profitable;
	logic [bbpt_pkg::CNT_W-1:0]    closed_trades;
	logic [bbpt_pkg::CNT_W-1:0]    winning_trades;
	logic [bbpt_pkg::TOT_W-1:0]    return_total;
	modport source (output valid, output action_code, output trade_return,
		output trade_profitable, output closed_trades, output winning_trades,
		output return_total, input ready);
	modport sink (input valid, input action_code, input trade_return,
		input trade_profitable, input closed_trades, input winning_trades,
		input return_total, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bbpt_front.sv
// Front end: sliding window, running sums and exact band classification.
`default_nettype none
module bbpt_front #(
	parameter int WINDOW     = bbpt_pkg::WINDOW_DEF,
	parameter int PRICE_BITS = bbpt_pkg::PRICE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bbpt_in_if.sink            candle,
	output bbpt_pkg::item_t    push_item,
	output logic               push,
	input  wire logic          q_full
);
	localparam int CW     = $clog2(WINDOW);
	localparam int SUM_W  = PRICE_BITS + CW;
	localparam int SQ_W   = 2 * PRICE_BITS + CW;
	localparam int D_W    = SUM_W + 1;
	localparam int V_W    = SQ_W + CW + 1;
	localparam int CMP_W  = V_W + 2;
	localparam int SEEN_W = $clog2(WINDOW + 2);
	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WINDOW + 1);

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_SQ   = 6'b000010,
		F_SUM  = 6'b000100,
		F_MUL  = 6'b001000,
		F_CMP  = 6'b010000,
		F_PUSH = 6'b100000
	} fstate_t;

	fstate_t                  state_q;
	logic [PRICE_BITS-1:0]    win_q [WINDOW];
	logic [PRICE_BITS-1:0]    price_q, old_q;
	logic                     final_q, decide_q;
	logic [SEEN_W-1:0]        seen_q;
	logic [2*PRICE_BITS-1:0]  psq_q, osq_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SQ_W-1:0]          sqsum_q;
	logic signed [D_W-1:0]    d_q;
	logic [2*SUM_W-1:0]       sumsq_q;
	logic [V_W-1:0]           wsq_q;
	logic [2*SUM_W-1:0]       dsq_q;
	logic [CMP_W-1:0]         v4_q;
	logic [SUM_W-1:0]         wp, ad;
	logic signed [D_W-1:0]    d_neg_val;
	logic [V_W-1:0]           v;
	logic                     accept, outside, d_pos, d_neg;
	logic [SEEN_W-1:0]        seen_next;

	assign candle.ready = (state_q == F_IDLE);
	assign accept       = candle.valid && candle.ready;
	assign seen_next    = (seen_q < SEEN_MAX) ? seen_q + SEEN_W'(1) : seen_q;

	// Arithmetic for the band tests.
	assign wp        = SUM_W'(WINDOW) * SUM_W'(price_q);
	assign d_neg_val = -d_q;
	assign ad        = d_q[D_W-1] ? d_neg_val[SUM_W-1:0] : d_q[SUM_W-1:0];
	assign v         = wsq_q - V_W'(sumsq_q);
	assign outside   = CMP_W'(dsq_q) >= v4_q;
	assign d_neg     = d_q[D_W-1];
	assign d_pos     = !d_q[D_W-1] && (d_q != '0);

	assign push = (state_q == F_PUSH) && !q_full;
	always_comb begin
		push_item          = '0;
		push_item.price    = bbpt_pkg::PRICE_W'(price_q);
		push_item.final_c  = final_q;
		push_item.decide   = decide_q;
		push_item.at_lower = !d_pos && outside;
		push_item.at_upper = !d_neg && outside;
		push_item.d_pos    = d_pos;
		push_item.d_neg    = d_neg;
	end

	// Sequencer over the arithmetic steps of one candle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			seen_q  <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						win_q[0] <= candle.close_price[PRICE_BITS-1:0];
						for (int i = 1; i < WINDOW; i++) win_q[i] <= win_q[i-1];
						seen_q  <= seen_next;
						state_q <= F_SQ;
					end
				end
				F_SQ:   state_q <= F_SUM;
				F_SUM: begin
					sum_q   <= sum_q - SUM_W'(old_q) + SUM_W'(price_q);
					sqsum_q <= sqsum_q - SQ_W'(osq_q) + SQ_W'(psq_q);
					state_q <= F_MUL;
				end
				F_MUL:  state_q <= F_CMP;
				F_CMP:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!q_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Data registers of the sequencer.
	always_ff @(posedge clk) begin
		if (accept) begin
			price_q  <= candle.close_price[PRICE_BITS-1:0];
			final_q  <= candle.final_candle;
			old_q    <= win_q[WINDOW-1];
			decide_q <= (seen_next >= SEEN_MAX);
		end
		if (state_q == F_SQ) begin
			psq_q <= price_q * price_q;
			osq_q <= old_q * old_q;
		end
		if (state_q == F_MUL) begin
			d_q     <= $signed({1'b0, wp}) - $signed({1'b0, sum_q});
			sumsq_q <= (2*SUM_W)'(sum_q) * (2*SUM_W)'(sum_q);
			wsq_q   <= V_W'(WINDOW) * V_W'(sqsum_q);
		end
		if (state_q == F_CMP) begin
			dsq_q <= (2*SUM_W)'(ad) * (2*SUM_W)'(ad);
			v4_q  <= {v, 2'b00};
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/bbpt_queue.sv
// Short queue of classified candles between the front and the back.
`default_nettype none
module bbpt_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bbpt_pkg::item_t   push_item,
	input  wire logic              pop,
	output bbpt_pkg::item_t        head,
	output bbpt_pkg::qstat_t       stat
);
	localparam int PW = $clog2(bbpt_pkg::QDEPTH);

	bbpt_pkg::item_t   mem_q [bbpt_pkg::QDEPTH];
	logic [PW-1:0]     wptr_q, rptr_q;
	logic [PW:0]       count_q;

	assign head       = mem_q[rptr_q];
	assign stat.full  = (count_q == (PW+1)'(bbpt_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + PW'(1);
			if (pop)  rptr_q <= rptr_q + PW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_item;
	end
endmodule
`default_nettype wire

// File: hw/rtl/bbpt_back.sv
// Back end: position machine, serial return divider, counters and result register.
`default_nettype none
module bbpt_back #(
	parameter int PRICE_BITS = bbpt_pkg::PRICE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bbpt_pkg::THR_W-1:0]    cfg_data,
	input  wire bbpt_pkg::item_t               head,
	input  wire logic                          q_empty,
	output logic                               pop,
	output logic                               busy,
	bbpt_out_if.source                         report
);
	localparam int NUM_W = PRICE_BITS + bbpt_pkg::FRAC_BITS;
	localparam int CNT_BITS = $clog2(NUM_W + 1);
	localparam int TW = bbpt_pkg::THR_W;
	localparam int OW = bbpt_pkg::TOT_W;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_FIN  = 3'b100
	} bstate_t;

	bstate_t                       state_q;
	bbpt_pkg::pos_t                pos_q, pos_dec;
	logic [PRICE_BITS-1:0]         entry_q, entry_dec, price;
	logic signed [TW-1:0]          thr_q;
	logic [bbpt_pkg::CNT_W-1:0]    trades_q, wins_q;
	logic signed [OW-1:0]          acc_q;
	logic [PRICE_BITS:0]           rem_q, trial;
	logic [PRICE_BITS-1:0]         den_q, mag;
	logic [NUM_W-1:0]              num_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          neg_q, neg, do_close, close_long;
	bbpt_pkg::action_t             act_dec, act_q;
	logic                          start;
	logic signed [TW-1:0]          qx, r;
	logic                          win;
	logic signed [OW:0]            s;

	assign price = head.price[PRICE_BITS-1:0];
	assign start = (state_q == B_IDLE) && !q_empty && (!report.valid || report.ready);
	assign pop   = start;
	assign busy  = (state_q != B_IDLE);

	// Position decision for the candle at the head of the queue.
	always_comb begin
		pos_dec    = pos_q;
		entry_dec  = entry_q;
		act_dec    = bbpt_pkg::ACT_NONE;
		do_close   = 1'b0;
		close_long = 1'b0;
		if (head.decide) begin
			case (pos_q)
				bbpt_pkg::POS_FLAT: begin
					if (head.at_lower) begin
						pos_dec   = bbpt_pkg::POS_LONG;
						entry_dec = price;
						act_dec   = bbpt_pkg::ACT_LONG_IN;
					end else if (head.at_upper) begin
						pos_dec   = bbpt_pkg::POS_SHORT;
						entry_dec = price;
						act_dec   = bbpt_pkg::ACT_SHORT_IN;
					end
				end
				bbpt_pkg::POS_LONG: begin
					if (head.at_upper || head.d_pos) begin
						do_close   = 1'b1;
						close_long = 1'b1;
						act_dec    = bbpt_pkg::ACT_LONG_OUT;
						pos_dec    = bbpt_pkg::POS_FLAT;
					end
				end
				default: begin
					if (head.at_lower || head.d_neg) begin
						do_close = 1'b1;
						act_dec  = bbpt_pkg::ACT_SHORT_OUT;
						pos_dec  = bbpt_pkg::POS_FLAT;
					end
				end
			endcase
		end
		// The final candle closes whatever is still open.
		if (head.final_c && pos_dec != bbpt_pkg::POS_FLAT) begin
			do_close   = 1'b1;
			close_long = (pos_dec == bbpt_pkg::POS_LONG);
			act_dec    = close_long ? bbpt_pkg::ACT_LONG_OUT : bbpt_pkg::ACT_SHORT_OUT;
			pos_dec    = bbpt_pkg::POS_FLAT;
		end
	end

	// Magnitude and sign of the price move.
	always_comb begin
		if (price >= entry_dec) begin
			mag = price - entry_dec;
			neg = !close_long;
		end else begin
			mag = entry_dec - price;
			neg = close_long;
		end
	end

	// Divider step and final return.
	assign trial = {rem_q[PRICE_BITS-1:0], num_q[NUM_W-1]};
	assign qx    = TW'(num_q);
	assign r     = neg_q ? -qx : qx;
	assign win   = r > thr_q;
	assign s     = $signed({acc_q[OW-1], acc_q}) + $signed({{(OW+1-TW){r[TW-1]}}, r});

	// Control state and running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			pos_q        <= bbpt_pkg::POS_FLAT;
			entry_q      <= '0;
			thr_q        <= '0;
			trades_q     <= '0;
			wins_q       <= '0;
			acc_q        <= '0;
			report.valid <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_data;
			// The result register fills on a candle that closes no trade, or in the final step of a closing trade.
			if ((start && !do_close) || state_q == B_FIN)
				report.valid <= 1'b1;
			else if (report.ready)
				report.valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (start) begin
						pos_q   <= pos_dec;
						entry_q <= entry_dec;
						if (do_close) begin
							if (entry_dec == '0)
								state_q <= B_FIN;
							else
								state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					if (cnt_q == CNT_BITS'(NUM_W - 1)) state_q <= B_FIN;
				end
				B_FIN: begin
					if (trades_q != '1) trades_q <= trades_q + 1'b1;
					if (win && wins_q != '1) wins_q <= wins_q + 1'b1;
					if (s[OW] != s[OW-1])
						acc_q <= s[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
					else
						acc_q <= s[OW-1:0];
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Divider datapath and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (start) begin
					act_q <= act_dec;
					neg_q <= neg;
					den_q <= entry_dec;
					rem_q <= '0;
					cnt_q <= '0;
					num_q <= (entry_dec == '0) ? '0 : {mag, {bbpt_pkg::FRAC_BITS{1'b0}}};
					if (!do_close) begin
						report.action_code      <= act_dec;
						report.trade_return     <= '0;
						report.trade_profitable <= 1'b0;
						report.closed_trades    <= trades_q;
						report.winning_trades   <= wins_q;
						report.return_total     <= acc_q;
					end
				end
			end
			B_DIV: begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			B_FIN: begin
				report.action_code      <= act_q;
				report.trade_return     <= r;
				report.trade_profitable <= win;
				report.closed_trades    <= (trades_q != '1) ? trades_q + 1'b1 : trades_q;
				report.winning_trades   <= (win && wins_q != '1) ? wins_q + 1'b1 : wins_q;
				if (s[OW] != s[OW-1])
					report.return_total <= s[OW] ? {1'b1, {(OW-1){1'b0}}}
						: {1'b0, {(OW-1){1'b1}}};
				else
					report.return_total <= s[OW-1:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/bollinger_band_position_tracker.sv
// Top level of the Bollinger band position tracker.
//
// Each candle beat gives exactly one result beat. The front end takes one candle at a
// time: accept with window update, squares, running sums, band products, compare, queue
// push (which waits while the queue is full); a two-entry queue decouples it from the
// back end. The back end reports a candle that closes no trade in the cycle after it is
// popped; a closing trade with a nonzero entry price runs the restoring divider, which
// forms the Q16 return one quotient bit per cycle. The profit threshold must be written
// through cfg_we/cfg_data only while idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module bollinger_band_position_tracker #(
	parameter int WINDOW     = bbpt_pkg::WINDOW_DEF,
	parameter int PRICE_BITS = bbpt_pkg::PRICE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bbpt_pkg::THR_W-1:0]    cfg_data,
	bbpt_in_if.sink                            candle,
	bbpt_out_if.source                         report
);
	bbpt_pkg::item_t   push_item, head;
	bbpt_pkg::qstat_t  q_stat;
	logic              push, pop, busy;

	bbpt_front #(.WINDOW(WINDOW), .PRICE_BITS(PRICE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .candle(candle),
		.push_item(push_item), .push(push), .q_full(q_stat.full)
	);

	bbpt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .head(head), .stat(q_stat)
	);

	bbpt_back #(.PRICE_BITS(PRICE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.head(head), .q_empty(q_stat.empty), .pop(pop), .busy(busy), .report(report)
	);

	// The queue is never written while full nor read while empty.
	`BBPT_ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, !q_stat.full)
	`BBPT_ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty)
	// While a trade return is being computed no result is presented.
	`BBPT_ASSERT_IMPLIES(a_busy_no_out, clk, arst_n, busy, !report.valid)
	// A popped candle with a free output register is reported or makes the back end busy.
	`BBPT_ASSERT_NEXT(a_pop_progress, clk, arst_n, pop, report.valid || busy)
endmodule
`default_nettype wire

// File: sim/bbpt_tb_if.sv
// Testbench package with the fixed window length of the bench.
`timescale 1ns / 1ps
package bbpt_tb_pkg;
	// Fixed window of the tracker as built for this bench.
	localparam int BAND_WINDOW = 20;
endpackage

// File: sim/bbpt_checker.sv
// Checker that predicts the tracker's results and compares them beat by beat.
`timescale 1ns / 1ps
module bbpt_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bbpt_pkg::THR_W-1:0]    cfg_data,
	bbpt_in_if                                 candle,
	bbpt_out_if                                report,
	output int                                 fail_count,
	output int                                 pending_count,
	output int                                 trades_seen
);
	typedef struct packed {
		logic [bbpt_pkg::ACT_W-1:0] act;
		logic [bbpt_pkg::THR_W-1:0] ret;
		logic                       prof;
		logic [bbpt_pkg::CNT_W-1:0] closed;
		logic [bbpt_pkg::CNT_W-1:0] wins;
		logic [bbpt_pkg::TOT_W-1:0] total;
	} verdict_t;

	verdict_t                          verdict_q[$];
	logic [bbpt_pkg::PRICE_W-1:0]      prices[bbpt_tb_pkg::BAND_WINDOW];
	int                                head;
	longint unsigned                   psum;
	longint unsigned                   psq;
	int                                seen;
	bbpt_pkg::pos_t                    pos;
	logic [bbpt_pkg::PRICE_W-1:0]      entry;
	logic [bbpt_pkg::CNT_W-1:0]        n_closed;
	logic [bbpt_pkg::CNT_W-1:0]        n_wins;
	longint                            total;
	longint                            threshold;

	// Signed Q16 return of a trade, truncated toward zero.
	function automatic longint q16_gain(logic [bbpt_pkg::PRICE_W-1:0] ein,
			logic [bbpt_pkg::PRICE_W-1:0] eout, bit is_long);
		longint unsigned mag;
		bit neg;
		if (ein == 0)
			return 0;
		if (eout >= ein) begin
			mag = eout - ein;
			neg = !is_long;
		end else begin
			mag = ein - eout;
			neg = is_long;
		end
		mag = (mag << 16) / ein;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	// Book one closed trade into the counters and the verdict.
	function automatic void book_trade(longint r, inout verdict_t v);
		bit win;
		win = r > threshold;
		if (n_closed != '1)
			n_closed++;
		if (win && n_wins != '1)
			n_wins++;
		if (r > 0 && total > 64'sh7fffffffffffffff - r)
			total = 64'sh7fffffffffffffff;
		else if (r < 0 && total < -64'sh7fffffffffffffff - 1 - r)
			total = -64'sh7fffffffffffffff - 1;
		else
			total += r;
		v.ret = r[bbpt_pkg::THR_W-1:0];
		v.prof = win;
		pos = bbpt_pkg::POS_FLAT;
	endfunction

	// Expected result of one candle beat.
	function automatic verdict_t band_decision(logic [bbpt_pkg::PRICE_W-1:0] p, bit fin);
		verdict_t v;
		logic [bbpt_pkg::PRICE_W-1:0] old;
		longint d;
		longint unsigned ad, dsq, v4;
		bit outside, lo, hi, lng;
		v = '0;
		old = prices[head];
		psum = psum - old + p;
		psq = psq - longint'(old) * old + longint'(p) * p;
		prices[head] = p;
		head = (head + 1 >= bbpt_tb_pkg::BAND_WINDOW) ? 0 : head + 1;
		if (seen < bbpt_tb_pkg::BAND_WINDOW + 1)
			seen++;
		if (seen >= bbpt_tb_pkg::BAND_WINDOW + 1) begin
			d = bbpt_tb_pkg::BAND_WINDOW * longint'(p) - longint'(psum);
			ad = d < 0 ? -d : d;
			dsq = ad * ad;
			v4 = 4 * (bbpt_tb_pkg::BAND_WINDOW * psq - psum * psum);
			outside = dsq >= v4;
			lo = d <= 0 && outside;
			hi = d >= 0 && outside;
			if (pos == bbpt_pkg::POS_FLAT) begin
				if (lo) begin
					pos = bbpt_pkg::POS_LONG;
					entry = p;
					v.act = bbpt_pkg::ACT_LONG_IN;
				end else if (hi) begin
					pos = bbpt_pkg::POS_SHORT;
					entry = p;
					v.act = bbpt_pkg::ACT_SHORT_IN;
				end
			end else if (pos == bbpt_pkg::POS_LONG) begin
				if (hi || d > 0) begin
					book_trade(q16_gain(entry, p, 1), v);
					v.act = bbpt_pkg::ACT_LONG_OUT;
				end
			end else if (lo || d < 0) begin
				book_trade(q16_gain(entry, p, 0), v);
				v.act = bbpt_pkg::ACT_SHORT_OUT;
			end
		end
		if (fin && pos != bbpt_pkg::POS_FLAT) begin
			lng = pos == bbpt_pkg::POS_LONG;
			book_trade(q16_gain(entry, p, lng), v);
			v.act = lng ? bbpt_pkg::ACT_LONG_OUT : bbpt_pkg::ACT_SHORT_OUT;
		end
		v.closed = n_closed;
		v.wins = n_wins;
		v.total = total;
		return v;
	endfunction

	assign trades_seen = int'(n_closed);

	// Predict on candle beats, compare on report beats.
	always @(posedge clk or negedge arst_n) begin
		verdict_t e;
		if (!arst_n) begin
			verdict_q.delete();
			foreach (prices[i])
				prices[i] = '0;
			head = 0;
			psum = 0;
			psq = 0;
			seen = 0;
			pos = bbpt_pkg::POS_FLAT;
			entry = '0;
			n_closed = '0;
			n_wins = '0;
			total = 0;
			threshold = 0;
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we)
				threshold = longint'(signed'(cfg_data));
			if (candle.valid && candle.ready)
				verdict_q.insert(verdict_q.size(),
					band_decision(candle.close_price, candle.final_candle));
			if (report.valid && report.ready) begin
				if (verdict_q.size() == 0) begin
					$error("unexpected result beat");
					fail_count++;
				end else begin
					e = verdict_q.pop_front();
					if (report.action_code !== e.act) begin
						$error("action_code exp %0d got %0d", e.act, report.action_code);
						fail_count++;
					end
					if (report.trade_return !== e.ret) begin
						$error("trade_return exp %0h got %0h", e.ret, report.trade_return);
						fail_count++;
					end
					if (report.trade_profitable !== e.prof) begin
						$error("trade_profitable exp %0d got %0d", e.prof,
							report.trade_profitable);
						fail_count++;
					end
					if (report.closed_trades !== e.closed) begin
						$error("closed_trades exp %0d got %0d", e.closed, report.closed_trades);
						fail_count++;
					end
					if (report.winning_trades !== e.wins) begin
						$error("winning_trades exp %0d got %0d", e.wins, report.winning_trades);
						fail_count++;
					end
					if (report.return_total !== e.total) begin
						$error("return_total exp %0h got %0h", e.total, report.return_total);
						fail_count++;
					end
				end
			end
			pending_count = verdict_q.size();
		end
	end
endmodule

// File: sim/testbench.sv
// Top of the tracker bench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module testbench;
	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       cfg_we = 0;
	logic [bbpt_pkg::THR_W-1:0] cfg_data = '0;
	int                         fail_count, pending_count, trades_seen;
	int                         beats_sent = 0;
	bit                         hold_off = 0;

	bbpt_in_if  candle();
	bbpt_out_if report();

	bollinger_band_position_tracker uut (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_data(cfg_data), .candle(candle), .report(report));

	bbpt_checker chk (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.candle(candle), .report(report), .fail_count(fail_count),
		.pending_count(pending_count), .trades_seen(trades_seen));

	always #5 clk = ~clk;

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		int mode;
		report.ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				report.ready <= 0;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			mode = (beats_sent / 200) % 3;
			report.ready <= mode == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// Offer one candle and wait until it is taken.
	task automatic send_candle(logic [bbpt_pkg::PRICE_W-1:0] p, bit fin);
		candle.valid <= 1;
		candle.close_price <= p;
		candle.final_candle <= fin;
		do
			@(posedge clk);
		while (!candle.ready);
		beats_sent++;
	endtask

	// Sender bursts with random gaps; gaps are skipped in some stretches.
	task automatic send_burst_gap();
		if ((beats_sent / 300) % 2 == 1 && $urandom_range(0, 4) == 0) begin
			candle.valid <= 0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
	endtask

	// Set the profit threshold while nothing is in flight.
	task automatic set_threshold(logic [bbpt_pkg::THR_W-1:0] t);
		candle.valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Random session: a walk of prices with swings, ending on a final candle.
	task automatic session(int len, int scale);
		logic [bbpt_pkg::PRICE_W-1:0] p;
		int step;
		p = bbpt_pkg::PRICE_W'($urandom_range(1000, 16000000));
		for (int i = 0; i < len; i++) begin
			step = $urandom_range(0, 2 * scale) - scale;
			if ($urandom_range(0, 15) == 0)
				step = step * 8;
			if (int'(p) + step < 1)
				p = bbpt_pkg::PRICE_W'(1);
			else if (int'(p) + step > 24'hffffff)
				p = 24'hffffff;
			else
				p = bbpt_pkg::PRICE_W'(int'(p) + step);
			if ($urandom_range(0, 30) == 0)
				p = bbpt_pkg::PRICE_W'($urandom_range(1, 24'hffffff));
			send_candle(p, i == len - 1 || $urandom_range(0, 150) == 0);
			send_burst_gap();
		end
	endtask

	initial begin
		int limit;
		candle.valid <= 0;
		candle.close_price <= '0;
		candle.final_candle <= 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: flat warm-up, equal bands, extremes, entry on the final candle.
		for (int i = 0; i < 21; i++)
			send_candle(24'd5000, i == 3);
		send_candle(24'hffffff, 0);
		send_candle(24'd1, 0);
		send_candle(24'd1, 1);
		send_candle(24'h800000, 1);

		set_threshold(41'h0ffffffffff);
		session(120, 50000);
		set_threshold(41'h10000000000);
		session(120, 2000);
		set_threshold(41'd300);

		// Pressure: long receiver hold-off while the sender keeps going.
		hold_off = 1;
		session(150, 300000);
		set_threshold(-41'sd500);
		while (beats_sent < 1700)
			session($urandom_range(25, 200), $urandom_range(10, 400000));

		candle.valid <= 0;
		@(posedge clk);
		limit = 0;
		while (pending_count != 0 && limit < 200000) begin
			@(posedge clk);
			limit++;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d candles over five threshold settings; %0d trades closed.",
			beats_sent, trades_seen);
		if (fail_count == 0 && pending_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
